// File: src/plid_pkg.sv
// Shared types and constants for the positional list insert/delete unit.
// No dependencies; used by plid_cell and positional_list_insert_delete_unit.
`timescale 1ns / 1ps
`default_nettype none
package plid_pkg;

    localparam int PLID_CAPACITY = 32;
    localparam int PLID_DATA_W   = 32;
    localparam int PLID_POS_W    = 6;
    localparam int PLID_CNT_W    = 6;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]                    func;
        logic [PLID_POS_W-1:0]         position;
        logic signed [PLID_DATA_W-1:0] new_value;
    } t_item;

    typedef struct packed {
        logic                          status;
        logic signed [PLID_DATA_W-1:0] read_value;
        logic [PLID_CNT_W-1:0]         count_after;
    } t_result;

    typedef struct packed {
        logic                          shift_up;
        logic                          shift_down;
        logic [PLID_POS_W-1:0]         idx;
        logic signed [PLID_DATA_W-1:0] new_value;
    } t_cmd;

endpackage
`default_nettype wire

// File: src/plid_cell.sv
// One storage cell of the list chain: holds one element, takes from its neighbors.
// Depends on plid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plid_cell
    import plid_pkg::*;
#(
    parameter int Index = 0
) (
    input  wire logic                          i_clk,
    input  wire t_cmd                          i_cmd,
    input  wire logic signed [PLID_DATA_W-1:0] i_left,
    input  wire logic signed [PLID_DATA_W-1:0] i_right,
    output logic signed [PLID_DATA_W-1:0]      o_word,
    output logic signed [PLID_DATA_W-1:0]      o_tap
);

    logic signed [PLID_DATA_W-1:0] r_word;
    logic signed [PLID_DATA_W-1:0] n_word;
    logic                          w_hit;
    logic                          w_above;

    assign w_hit   = (int'(i_cmd.idx) == Index);
    assign w_above = (int'(i_cmd.idx) < Index);

    always_comb begin
        n_word = r_word;
        if (i_cmd.shift_up) begin
            if (w_hit) begin
                n_word = i_cmd.new_value;
            end else if (w_above) begin
                n_word = i_left;
            end
        end else if (i_cmd.shift_down) begin
            if (w_hit || w_above) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = w_hit ? r_word : '0;

endmodule
`default_nettype wire

// File: src/positional_list_insert_delete_unit.sv
// Positional list insert/delete unit: a chain of element cells with one result per item.
// Depends on plid_pkg and plid_cell.
// The result strobe is registered at the accepting edge. Throughput: one item per
// cycle; busy stays low, since every cell shifts in the same cycle the item is taken.
// The receiver cannot stall: each result strobes for exactly one cycle.
// Reset clears the element count and the strobe; cell contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_insert_delete_unit
    import plid_pkg::*;
#(
    parameter int CAPACITY = PLID_CAPACITY
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_item i_item,
    output logic       o_strobe,
    output t_result    o_result
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic [CntW-1:0]               r_count;
    logic [CntW-1:0]               n_count;
    logic                          r_strobe;
    t_result                       r_result;
    t_result                       n_result;
    t_cmd                          w_cmd;
    logic                          w_accept;
    logic                          w_pos_ok;
    logic                          w_ins_ok;
    logic                          w_sel_ok;
    logic [31:0]                   w_cnt32;
    logic [31:0]                   w_pos32;
    logic [31:0]                   w_new32;
    logic signed [PLID_DATA_W-1:0] w_read;
    logic signed [PLID_DATA_W-1:0] w_word [CAPACITY];
    logic signed [PLID_DATA_W-1:0] w_tap  [CAPACITY];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_cnt32  = 32'(r_count);
    assign w_pos32  = 32'(i_item.position);
    assign w_pos_ok = (w_pos32 != 32'd0);
    assign w_sel_ok = w_pos_ok && (w_cnt32 != 32'd0) && (w_pos32 <= w_cnt32);
    assign w_ins_ok = w_pos_ok && (w_cnt32 < 32'(CAPACITY)) && (w_pos32 <= w_cnt32 + 32'd1);

    always_comb begin
        w_cmd.shift_up   = w_accept && (i_item.func == OP_INSERT) && w_ins_ok;
        w_cmd.shift_down = w_accept && (i_item.func == OP_DELETE) && w_sel_ok;
        w_cmd.idx        = i_item.position - PLID_POS_W'(1);
        w_cmd.new_value  = i_item.new_value;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plid_cell #(
            .Index(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_left ((g == 0) ? i_item.new_value : w_word[(g == 0) ? 0 : g - 1]),
            .i_right((g == CAPACITY - 1) ? w_word[g] :
                     w_word[(g == CAPACITY - 1) ? g : g + 1]),
            .o_word (w_word[g]),
            .o_tap  (w_tap[g])
        );
    end

    always_comb begin
        w_read = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_read = w_read | w_tap[k];
        end
    end

    always_comb begin
        n_count             = r_count;
        n_result.status     = 1'b1;
        n_result.read_value = '0;
        case (i_item.func)
            OP_READ: begin
                if (w_sel_ok) begin
                    n_result.status     = 1'b0;
                    n_result.read_value = w_read;
                end
            end
            OP_INSERT: begin
                if (w_ins_ok) begin
                    n_result.status = 1'b0;
                    n_count         = r_count + CntW'(1);
                end
            end
            OP_DELETE: begin
                if (w_sel_ok) begin
                    n_result.status     = 1'b0;
                    n_result.read_value = w_read;
                    n_count             = r_count - CntW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        w_new32              = 32'(n_count);
        n_result.count_after = w_new32[PLID_CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// File: tb/positional_list_insert_delete_unit_tb.sv
// Testbench for positional_list_insert_delete_unit: a directed table, then random
// grow/shrink/mixed phases, every result checked against a list predictor or a pinned value.
// Depends on plid_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module positional_list_insert_delete_unit_tb;
    import plid_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET = 1650;
    localparam int         CYCLE_LIMIT = 400000;

    typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} t_phase;

    typedef struct packed {
        t_item   it;
        logic    pinned;
        t_result want;
    } t_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;

    logic    pin_valid;
    t_result pin_result;

    logic signed [PLID_DATA_W-1:0] list_words [0:PLID_CAPACITY-1];
    int                            list_len;
    t_result                       pending_results [$];
    t_row                          directed_rows [$];
    int                            mismatch_count;
    int                            cycle_count;

    positional_list_insert_delete_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result apply_list_op(input t_item it);
        t_result r;
        int      pos;
        int      k;
        pos          = int'(it.position);
        r.status     = 1'b1;
        r.read_value = '0;
        case (it.func)
            OP_READ: begin
                if (list_len != 0 && pos >= 1 && pos <= list_len) begin
                    r.read_value = list_words[pos-1];
                    r.status     = 1'b0;
                end
            end
            OP_INSERT: begin
                if (list_len < PLID_CAPACITY && pos >= 1 && pos <= list_len + 1) begin
                    for (k = list_len; k > pos - 1; k--)
                        list_words[k] = list_words[k-1];
                    list_words[pos-1] = it.new_value;
                    list_len++;
                    r.status = 1'b0;
                end
            end
            OP_DELETE: begin
                if (list_len != 0 && pos >= 1 && pos <= list_len) begin
                    r.read_value = list_words[pos-1];
                    for (k = pos; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                    r.status = 1'b0;
                end
            end
            default: ;
        endcase
        r.count_after = PLID_CNT_W'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL positional_list_insert_delete_unit");
            $finish;
        end
        if (i_rst_n) begin
            if (o_strobe) begin
                got = o_result;
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: status=%0b value=%0d count=%0d",
                                 got.status, got.read_value, got.count_after);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.read_value !== want.read_value ||
                        got.count_after !== want.count_after) begin
                        if (mismatch_count < 10) begin
                            $write("mismatch: exp status=%0b value=%0d count=%0d",
                                   want.status, want.read_value, want.count_after);
                            $display(" got status=%0b value=%0d count=%0d",
                                     got.status, got.read_value, got.count_after);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                want = apply_list_op(i_item);
                pending_results.push_back(pin_valid ? pin_result : want);
            end
        end
    end

    task automatic add_row(input logic [1:0] func, input int pos, input logic [31:0] val,
                           input logic pinned, input logic st, input logic [31:0] rv,
                           input int cnt);
        t_row row;
        row.it.func          = func;
        row.it.position      = PLID_POS_W'(pos);
        row.it.new_value     = val;
        row.pinned           = pinned;
        row.want.status      = st;
        row.want.read_value  = rv;
        row.want.count_after = PLID_CNT_W'(cnt);
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input t_item it, input logic pinned, input t_result want,
                             input bit quiet);
        int gap;
        int r;
        start      <= 1'b1;
        i_item     <= it;
        pin_valid  <= pinned;
        pin_result <= want;
        do @(posedge i_clk); while (busy);
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap != 0) begin
            start  <= 1'b0;
            i_item <= t_item'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        t_item   it;
        t_result none;
        t_phase  phase;
        int      sent;
        int      phase_len;
        int      ins_lim;
        int      del_lim;
        int      cnt;
        int      r;
        bit      quiet;

        none           = '0;
        list_len       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        sent           = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        pin_valid  <= 1'b0;
        pin_result <= '0;

        add_row(OP_READ,   1,  32'h5A5A_A5A5, 1, 1, 32'h0,         0);
        add_row(OP_DELETE, 1,  32'h5A5A_A5A5, 1, 1, 32'h0,         0);
        add_row(OP_INSERT, 0,  32'h1234_5678, 1, 1, 32'h0,         0);
        add_row(OP_INSERT, 2,  32'h1234_5678, 1, 1, 32'h0,         0);
        add_row(OP_UNUSED, 1,  32'hFFFF_FFFF, 1, 1, 32'h0,         0);
        add_row(OP_INSERT, 1,  32'h7FFF_FFFF, 1, 0, 32'h0,         1);
        add_row(OP_INSERT, 1,  32'h8000_0000, 1, 0, 32'h0,         2);
        add_row(OP_INSERT, 3,  32'hFFFF_FFFF, 1, 0, 32'h0,         3);
        add_row(OP_INSERT, 5,  32'h0000_0001, 1, 1, 32'h0,         3);
        add_row(OP_READ,   1,  32'hFFFF_FFFF, 1, 0, 32'h8000_0000, 3);
        add_row(OP_READ,   3,  32'h0,         1, 0, 32'hFFFF_FFFF, 3);
        add_row(OP_READ,   0,  32'h0,         1, 1, 32'h0,         3);
        add_row(OP_READ,   4,  32'h0,         1, 1, 32'h0,         3);
        add_row(OP_READ,   63, 32'h0,         1, 1, 32'h0,         3);
        add_row(OP_INSERT, 2,  32'h0,         0, 0, 32'h0,         0);
        add_row(OP_DELETE, 0,  32'hA5A5_5A5A, 1, 1, 32'h0,         4);
        add_row(OP_DELETE, 5,  32'hA5A5_5A5A, 1, 1, 32'h0,         4);
        add_row(OP_DELETE, 2,  32'h0,         0, 0, 32'h0,         0);
        add_row(OP_DELETE, 3,  32'h0,         1, 0, 32'hFFFF_FFFF, 2);
        add_row(OP_UNUSED, 1,  32'h0,         1, 1, 32'h0,         2);
        add_row(OP_DELETE, 1,  32'h0,         1, 0, 32'h8000_0000, 1);
        add_row(OP_READ,   1,  32'h0,         0, 0, 32'h0,         0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n])
            send_item(directed_rows[n].it, directed_rows[n].pinned, directed_rows[n].want,
                      n % 2 == 0);

        while (sent < ITEM_TARGET) begin
            phase     = t_phase'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 80);
            quiet     = ($urandom_range(0, 3) == 0);
            case (phase)
                PH_GROW:   begin ins_lim = 80; del_lim = 90; end
                PH_SHRINK: begin ins_lim = 20; del_lim = 80; end
                default:   begin ins_lim = 40; del_lim = 70; end
            endcase
            for (int j = 0; j < phase_len && sent < ITEM_TARGET; j++) begin
                cnt          = list_len;
                r            = $urandom_range(0, 99);
                it.new_value = $urandom;
                if (r < 5)
                    it.func = OP_UNUSED;
                else if (r < ins_lim)
                    it.func = OP_INSERT;
                else if (r < del_lim)
                    it.func = OP_DELETE;
                else
                    it.func = OP_READ;
                if ($urandom_range(0, 99) < 8)
                    it.position = PLID_POS_W'($urandom_range(0, 63));
                else if (it.func == OP_INSERT)
                    it.position = PLID_POS_W'($urandom_range(1, cnt + 1));
                else
                    it.position = PLID_POS_W'($urandom_range(1, (cnt == 0) ? 1 : cnt));
                send_item(it, 1'b0, none, quiet);
                sent++;
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS positional_list_insert_delete_unit");
        else
            $display("FAIL positional_list_insert_delete_unit");
        $finish;
    end

endmodule

// File: files.f
src/plid_pkg.sv
src/plid_cell.sv
src/positional_list_insert_delete_unit.sv
tb/positional_list_insert_delete_unit_tb.sv
